// File: rtl/core/sclt_pkg.sv
// shared types, codes and helper functions of the character tokenizer
`timescale 1ns / 1ps
`default_nettype none

package sclt_pkg;

    localparam int LINE_W  = 16;
    localparam int MAX_RES = 4;

    // token classes, the escape and none codes live only in the front state
    localparam logic [2:0] CLS_INT   = 3'd0;
    localparam logic [2:0] CLS_DEC   = 3'd1;
    localparam logic [2:0] CLS_IDENT = 3'd2;
    localparam logic [2:0] CLS_STR   = 3'd3;
    localparam logic [2:0] CLS_OP    = 3'd4;
    localparam logic [2:0] CLS_ESC   = 3'd5;
    localparam logic [2:0] CLS_NONE  = 3'd7;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] CH_NONE  = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    localparam logic [LINE_W-1:0] LINE_RESET = 16'd1;
    localparam logic [LINE_W-1:0] LINE_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] chr;
        logic [2:0] cls;
    } res_t;

    // all results caused by one character, plus the line they report
    typedef struct packed {
        logic [2:0]              cnt;
        res_t [MAX_RES-1:0]      ent;
        logic [LINE_W-1:0]       line;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic bundle_t push_res(bundle_t b, logic [1:0] kind, logic [7:0] chr,
                                         logic [2:0] cls);
        bundle_t r;
        r = b;
        if (r.cnt < 3'(MAX_RES))
        begin
            r.ent[r.cnt[1:0]] = '{kind: kind, chr: chr, cls: cls};
            r.cnt = r.cnt + 3'd1;
        end
        return r;
    endfunction

    // an open escape ends as a string token
    function automatic logic [2:0] end_cls(logic [2:0] cls);
        return (cls == CLS_ESC) ? CLS_STR : cls;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sclt_char_if.sv
// character input channel
`timescale 1ns / 1ps
`default_nettype none

interface sclt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       text_last;

    modport source (output valid, output char_in, output text_last, input ready);
    modport sink (input valid, input char_in, input text_last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sclt_tok_if.sv
// token result channel
`timescale 1ns / 1ps
`default_nettype none

interface sclt_tok_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_char;
    logic [2:0]  token_class;
    logic [15:0] line_number;
    logic        run_last;

    modport source (output valid, output out_kind, output out_char, output token_class,
                    output line_number, output run_last, input ready);
    modport sink (input valid, input out_kind, input out_char, input token_class,
                  input line_number, input run_last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sclt_front.sv
// front end: classifies each character, keeps token state, builds the result bundle
`timescale 1ns / 1ps
`default_nettype none

module sclt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sclt_pkg::LINE_W-1:0]   cfg_wr_data,
    sclt_char_if.sink                     chars,
    input  sclt_pkg::q_status_t           q_stat,
    output logic                          push,
    output sclt_pkg::bundle_t             push_data
);
    import sclt_pkg::*;

    logic [2:0]        class_reg, class_next;
    logic [7:0]        pend_reg, pend_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              err_reg, err_next;
    logic              started_reg, started_next;
    logic [LINE_W-1:0] first_line_reg;

    logic       accept;
    logic [7:0] c;
    logic       in_str;
    logic       comp;
    logic       done;
    logic [7:0] esc_v;
    logic       esc_ok;
    bundle_t    b;

    assign c      = chars.char_in;
    assign accept = chars.valid && chars.ready;
    assign chars.ready = !q_stat.full;

    always_comb
    begin
        esc_ok = 1'b1;
        case (c)
            CH_N:    esc_v = CH_NL;
            CH_T:    esc_v = CH_TAB;
            CH_R:    esc_v = CH_CR;
            CH_BSL:  esc_v = CH_BSL;
            default:
            begin
                esc_v  = CH_NONE;
                esc_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        class_next   = class_reg;
        pend_next    = pend_reg;
        line_next    = line_reg;
        err_next     = err_reg;
        started_next = 1'b1;
        b            = '0;
        b.line       = line_reg;
        done         = 1'b0;
        comp         = 1'b0;
        in_str       = (class_reg == CLS_STR);

        if (!err_reg)
        begin
            // a held operator is completed or closed by this character
            if (pend_next != CH_NONE)
            begin
                comp = (pend_next == CH_AMP || pend_next == CH_BAR) ? (c == pend_next)
                                                                     : (c == CH_EQ);
                if (comp)
                begin
                    b    = push_res(b, KIND_CHAR, c, CLS_INT);
                    done = 1'b1;
                end
                b         = push_res(b, KIND_END, CH_NONE, CLS_OP);
                pend_next = CH_NONE;
            end

            if (!done)
            begin
                if (class_next == CLS_ESC)
                begin
                    if (esc_ok)
                    begin
                        b          = push_res(b, KIND_CHAR, esc_v, CLS_INT);
                        class_next = CLS_STR;
                    end
                    else
                    begin
                        b        = push_res(b, KIND_ERR, c, CLS_INT);
                        err_next = 1'b1;
                    end
                end
                else
                begin
                    case (c) inside
                        [CH_0:CH_9]:
                        begin
                            if (class_next == CLS_NONE)
                                class_next = CLS_INT;
                            b = push_res(b, KIND_CHAR, c, CLS_INT);
                        end
                        CH_DOT:
                        begin
                            if (!in_str)
                            begin
                                if (class_next == CLS_IDENT)
                                    b = push_res(b, KIND_END, CH_NONE, CLS_IDENT);
                                class_next = CLS_DEC;
                            end
                            b = push_res(b, KIND_CHAR, c, CLS_INT);
                        end
                        CH_LT, CH_GT, CH_BANG, CH_EQ, CH_AMP, CH_BAR:
                        begin
                            if (in_str)
                                b = push_res(b, KIND_CHAR, c, CLS_INT);
                            else
                            begin
                                if (class_next != CLS_NONE)
                                    b = push_res(b, KIND_END, CH_NONE, end_cls(class_next));
                                class_next = CLS_NONE;
                                b          = push_res(b, KIND_CHAR, c, CLS_INT);
                                pend_next  = c;
                            end
                        end
                        CH_LPAR, CH_RPAR, CH_COMMA, CH_COLON, CH_PLUS, CH_MINUS, CH_SLASH,
                        CH_PCT, CH_STAR, CH_BSL:
                        begin
                            // star inside an identifier and backslash inside a string
                            // are not operators
                            if (in_str && c == CH_BSL)
                                class_next = CLS_ESC;
                            else if (in_str || (c == CH_STAR && class_next == CLS_IDENT))
                                b = push_res(b, KIND_CHAR, c, CLS_INT);
                            else
                            begin
                                if (class_next != CLS_NONE)
                                    b = push_res(b, KIND_END, CH_NONE, end_cls(class_next));
                                class_next = CLS_NONE;
                                b          = push_res(b, KIND_CHAR, c, CLS_INT);
                                b          = push_res(b, KIND_END, CH_NONE, CLS_OP);
                            end
                        end
                        CH_SPACE, CH_TAB:
                        begin
                            if (in_str)
                                b = push_res(b, KIND_CHAR, c, CLS_INT);
                            else
                            begin
                                if (class_next != CLS_NONE)
                                    b = push_res(b, KIND_END, CH_NONE, end_cls(class_next));
                                class_next = CLS_NONE;
                            end
                        end
                        CH_NL, CH_CR:
                        begin
                            if (class_next != CLS_NONE)
                                b = push_res(b, KIND_END, CH_NONE, end_cls(class_next));
                            class_next = CLS_NONE;
                            if (line_reg != LINE_MAX)
                                line_next = line_reg + 16'd1;
                        end
                        CH_QUOTE:
                        begin
                            if (class_next != CLS_NONE)
                                b = push_res(b, KIND_END, CH_NONE, end_cls(class_next));
                            class_next = in_str ? CLS_NONE : CLS_STR;
                        end
                        default:
                        begin
                            if (class_next == CLS_NONE || class_next == CLS_INT ||
                                class_next == CLS_DEC)
                            begin
                                if (class_next != CLS_NONE)
                                    b = push_res(b, KIND_END, CH_NONE, class_next);
                                class_next = CLS_IDENT;
                            end
                            b = push_res(b, KIND_CHAR, c, CLS_INT);
                        end
                    endcase
                end
            end
        end

        if (chars.text_last)
        begin
            if (!err_next)
            begin
                if (pend_next != CH_NONE)
                    b = push_res(b, KIND_END, CH_NONE, CLS_OP);
                if (class_next != CLS_NONE)
                    b = push_res(b, KIND_END, CH_NONE, end_cls(class_next));
            end
            class_next   = CLS_NONE;
            pend_next    = CH_NONE;
            line_next    = first_line_reg;
            err_next     = 1'b0;
            started_next = 1'b0;
        end
    end

    assign push      = accept && (b.cnt != 3'd0);
    assign push_data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg      <= CLS_NONE;
            pend_reg       <= CH_NONE;
            line_reg       <= LINE_RESET;
            err_reg        <= 1'b0;
            started_reg    <= 1'b0;
            first_line_reg <= LINE_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                first_line_reg <= cfg_wr_data;
            if (accept)
            begin
                class_reg   <= class_next;
                pend_reg    <= pend_next;
                line_reg    <= line_next;
                err_reg     <= err_next;
                started_reg <= started_next;
            end
            else if (cfg_wr_en && !started_reg)
                line_reg <= cfg_wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sclt_queue.sv
// result bundle queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module sclt_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sclt_pkg::bundle_t    push_data,
    input  logic                 pop,
    output sclt_pkg::bundle_t    pop_data,
    output sclt_pkg::q_status_t  q_stat
);
    import sclt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sclt_back.sv
// back end: hands out the results of one bundle, one per transfer
`timescale 1ns / 1ps
`default_nettype none

module sclt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sclt_pkg::q_status_t  q_stat,
    input  sclt_pkg::bundle_t    pop_data,
    output logic                 pop,
    sclt_tok_if.source           tokens
);
    import sclt_pkg::*;

    bundle_t    bundle_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       last_one;
    res_t       cur;

    assign cur      = bundle_reg.ent[idx_reg];
    assign last_one = (({1'b0, idx_reg} + 3'd1) == bundle_reg.cnt);
    assign pop      = (!valid_reg || (tokens.ready && last_one)) && !q_stat.empty;

    assign tokens.valid       = valid_reg;
    assign tokens.out_kind    = cur.kind;
    assign tokens.out_char    = cur.chr;
    assign tokens.token_class = cur.cls;
    assign tokens.line_number = bundle_reg.line;
    assign tokens.run_last    = last_one;

    always_ff @(posedge clk)
    begin
        if (pop)
            bundle_reg <= pop_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && tokens.ready)
        begin
            if (last_one)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/spec_language_char_tokenizer.sv
// character tokenizer top level: front end, bundle queue and back end
// path: a character's results go into the queue, then into the back-end bundle register
// throughput: one character per cycle while the queue has room, one result per cycle out;
// the output port sets the sustained rate (up to four results per character)
// reset: token state cleared, no operator held, line counter and first_line at 1, queue empty
`timescale 1ns / 1ps
`default_nettype none

module spec_language_char_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sclt_pkg::LINE_W-1:0]   cfg_wr_data,
    sclt_char_if.sink                     chars,
    sclt_tok_if.source                    tokens
);
    import sclt_pkg::*;

    q_status_t q_stat;
    logic      push;
    logic      pop;
    bundle_t   push_data;
    bundle_t   pop_data;

    sclt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .chars       (chars),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    sclt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    sclt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .tokens   (tokens)
    );

endmodule

`default_nettype wire

// File: rtl/core/sclt_checker.sv
// port checks on the tokenizer output and their bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module sclt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  out_kind,
    input  logic [7:0]  out_char,
    input  logic [2:0]  token_class,
    input  logic [15:0] line_number,
    input  logic        run_last
);
    import sclt_pkg::*;

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_char) &&
        $stable(token_class) && $stable(line_number) && $stable(run_last))
        else $error("result changed while stalled");

    // token end carries a real class and no character
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_END |-> out_char == CH_NONE &&
        token_class <= CLS_OP)
        else $error("bad token end fields");

    // an escape error is always the final result of its character
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_ERR |-> run_last && token_class == CLS_INT)
        else $error("escape error not final");

    a_char_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_CHAR |-> token_class == CLS_INT)
        else $error("token character with class set");

endmodule

bind spec_language_char_tokenizer sclt_checker u_sclt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (tokens.valid),
    .out_ready   (tokens.ready),
    .out_kind    (tokens.out_kind),
    .out_char    (tokens.out_char),
    .token_class (tokens.token_class),
    .line_number (tokens.line_number),
    .run_last    (tokens.run_last)
);

`default_nettype wire
